### hdl/sfd_pkg.sv
// Shared constants, codes and interface structs of the S-Bus frame decoder.
// No dependencies; every other file of the block but sfd_ram refers to it by scoped names.
`timescale 1ns / 1ps

package sfd_pkg;

    // frame layout
    localparam int FRAME_BYTES = 25;
    localparam logic [7:0] START_MARK = 8'h0F;
    localparam logic [7:0] END_MARK   = 8'h00;
    localparam int CNT_BITS = 5;
    localparam logic [CNT_BITS-1:0] LAST_BYTE = CNT_BITS'(FRAME_BYTES - 1);
    localparam logic [CNT_BITS-1:0] SAFE_BYTE = CNT_BITS'(23);

    // frame memory: two banks of 32 byte slots, bank select is the address MSB
    localparam int RAM_WIDTH = 8;
    localparam int RAM_ABITS = CNT_BITS + 1;
    localparam int RAM_DEPTH = 1 << RAM_ABITS;

    // readout sequence: channel bytes 1..14, then the flag byte
    localparam logic [3:0] DATA_READS  = 4'd14;
    localparam logic [3:0] SAFE_READ   = 4'd14;
    localparam logic [3:0] FRAME_READS = 4'd15;

    localparam int CH_BITS  = 11;
    localparam int ACC_BITS = 18;
    localparam int OUT_BITS = 16;

    // channel numbers
    localparam logic [3:0] CH_RIGHT_Y = 4'd0;
    localparam logic [3:0] CH_RIGHT_X = 4'd1;
    localparam logic [3:0] CH_LEFT_X  = 4'd2;
    localparam logic [3:0] CH_LEFT_Y  = 4'd3;
    localparam logic [3:0] CH_SW_ONE  = 4'd4;
    localparam logic [3:0] CH_SW_TWO  = 4'd5;
    localparam logic [3:0] CH_SW_THR  = 4'd6;
    localparam logic [3:0] CH_SW_FOUR = 4'd7;
    localparam logic [3:0] CH_WHEEL_1 = 4'd8;
    localparam logic [3:0] CH_WHEEL_2 = 4'd9;

    // configuration registers
    localparam int ADDR_BITS = 3;
    localparam logic REG_CENTER = 1'b0;
    localparam logic REG_RECIP  = 1'b1;
    localparam logic [10:0] CENTER_RESET = 11'd1024;
    localparam logic [19:0] RECIP_RESET  = 20'd99864;

    typedef struct packed {
        logic               vld;
        logic [3:0]         num;
        logic [CH_BITS-1:0] raw;
    } t_chan;

    typedef struct packed {
        logic                       vld;
        logic [3:0]                 num;
        logic [CH_BITS-1:0]         raw;
        logic signed [OUT_BITS-1:0] val;
    } t_scaled;

    typedef struct packed {
        logic vld;
        logic flag;
    } t_safe;

    typedef struct packed {
        logic busy;
        logic drained;
    } t_eng_stat;

endpackage

### hdl/sfd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/sfd_unpack.sv
// Readout sequencer: reads a completed frame bank, unpacks 11-bit channels LSB first.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_unpack (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_bank,
    input  logic                           i_release,
    output logic                           o_rd_en,
    output logic [sfd_pkg::RAM_ABITS-1:0]  o_rd_addr,
    input  logic [sfd_pkg::RAM_WIDTH-1:0]  i_rd_data,
    output sfd_pkg::t_chan                 o_chan,
    output sfd_pkg::t_safe                 o_safe,
    output sfd_pkg::t_eng_stat             o_stat
);

    logic                          r_busy;
    logic                          r_bank;
    logic [3:0]                    r_issue;
    logic                          r_rd_vld;
    logic [3:0]                    r_rd_idx;
    logic [sfd_pkg::ACC_BITS-1:0]  r_acc;
    logic [sfd_pkg::CNT_BITS-1:0]  r_nbits;
    logic [3:0]                    r_ch_num;
    logic                          r_ch_vld;
    logic [3:0]                    r_ch_out_num;
    logic [sfd_pkg::CH_BITS-1:0]   r_ch_raw;
    logic                          r_safe_vld;
    logic                          r_safe_flag;

    logic                          issue;
    logic [sfd_pkg::CNT_BITS-1:0]  offset;
    logic                          rd_is_data;
    logic [sfd_pkg::ACC_BITS-1:0]  sum_acc;
    logic [sfd_pkg::CNT_BITS-1:0]  sum_bits;
    logic                          take;

    assign issue  = r_busy && (r_issue != sfd_pkg::FRAME_READS);
    assign offset = (r_issue < sfd_pkg::DATA_READS)
                  ? sfd_pkg::CNT_BITS'(r_issue + 4'd1) : sfd_pkg::SAFE_BYTE;

    assign o_rd_en   = issue;
    assign o_rd_addr = {r_bank, offset};

    // append the new byte above the leftover bits
    assign rd_is_data = r_rd_vld && (r_rd_idx < sfd_pkg::DATA_READS);
    assign sum_acc    = r_acc | (sfd_pkg::ACC_BITS'(i_rd_data) << r_nbits);
    assign sum_bits   = r_nbits + sfd_pkg::CNT_BITS'(8);
    assign take       = sum_bits >= sfd_pkg::CNT_BITS'(sfd_pkg::CH_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_issue    <= 4'd0;
            r_rd_vld   <= 1'b0;
            r_ch_vld   <= 1'b0;
            r_safe_vld <= 1'b0;
        end else begin
            r_rd_vld   <= issue;
            r_ch_vld   <= rd_is_data && take;
            r_safe_vld <= r_rd_vld && (r_rd_idx == sfd_pkg::SAFE_READ);
            if (i_start) begin
                r_busy  <= 1'b1;
                r_issue <= 4'd0;
            end else if (i_release) begin
                r_busy <= 1'b0;
            end else if (issue) begin
                r_issue <= r_issue + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= r_issue;
        r_safe_flag <= i_rd_data[2] | i_rd_data[3];
        if (i_start) begin
            r_bank   <= i_bank;
            r_acc    <= '0;
            r_nbits  <= '0;
            r_ch_num <= 4'd0;
        end else if (rd_is_data) begin
            if (take) begin
                r_acc        <= sum_acc >> sfd_pkg::CH_BITS;
                r_nbits      <= sum_bits - sfd_pkg::CNT_BITS'(sfd_pkg::CH_BITS);
                r_ch_raw     <= sum_acc[sfd_pkg::CH_BITS-1:0];
                r_ch_out_num <= r_ch_num;
                r_ch_num     <= r_ch_num + 4'd1;
            end else begin
                r_acc   <= sum_acc;
                r_nbits <= sum_bits;
            end
        end
    end

    assign o_chan.vld = r_ch_vld;
    assign o_chan.num = r_ch_out_num;
    assign o_chan.raw = r_ch_raw;

    assign o_safe.vld  = r_safe_vld;
    assign o_safe.flag = r_safe_flag;

    assign o_stat.busy    = r_busy;
    assign o_stat.drained = r_busy && (r_issue == sfd_pkg::FRAME_READS) && !r_rd_vld
                          && !r_ch_vld && !r_safe_vld;

endmodule

### hdl/sfd_scale.sv
// Three-stage centring and fixed-point scaling pipeline for unpacked channels.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfd_pkg::t_chan                i_chan,
    input  logic [sfd_pkg::CH_BITS-1:0]   i_center,
    input  logic [19:0]                   i_recip,
    output sfd_pkg::t_scaled              o_scaled,
    output logic                          o_empty
);

    logic                                r_v1;
    logic [3:0]                          r_num1;
    logic [sfd_pkg::CH_BITS-1:0]         r_raw1;
    logic signed [sfd_pkg::CH_BITS:0]    r_d;

    logic                                r_v2;
    logic [3:0]                          r_num2;
    logic [sfd_pkg::CH_BITS-1:0]         r_raw2;
    logic signed [32:0]                  r_p;

    logic                                r_v3;
    logic [3:0]                          r_num3;
    logic [sfd_pkg::CH_BITS-1:0]         r_raw3;
    logic signed [sfd_pkg::OUT_BITS-1:0] r_q;

    logic signed [20:0]                  q;
    logic signed [sfd_pkg::OUT_BITS-1:0] q_sat;

    // floor division by 4096, then clamp to 16 bits signed
    assign q = r_p[32:12];
    always_comb begin
        if ((q[20:15] == 6'b000000) || (q[20:15] == 6'b111111)) begin
            q_sat = q[15:0];
        end else if (q[20]) begin
            q_sat = 16'sh8000;
        end else begin
            q_sat = 16'sh7FFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_chan.vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num1 <= i_chan.num;
        r_raw1 <= i_chan.raw;
        r_d    <= $signed({1'b0, i_chan.raw}) - $signed({1'b0, i_center});
        r_num2 <= r_num1;
        r_raw2 <= r_raw1;
        r_p    <= r_d * $signed({1'b0, i_recip});
        r_num3 <= r_num2;
        r_raw3 <= r_raw2;
        r_q    <= q_sat;
    end

    assign o_scaled.vld = r_v3;
    assign o_scaled.num = r_num3;
    assign o_scaled.raw = r_raw3;
    assign o_scaled.val = r_q;
    assign o_empty      = !r_v1 && !r_v2 && !r_v3;

endmodule

### hdl/sbus_frame_decoder.sv
// S-Bus frame decoder top level: byte intake, frame memory, config port, result register.
// Depends on sfd_pkg, sfd_ram, sfd_unpack and sfd_scale.
`timescale 1ns / 1ps

// Takes one received S-Bus byte per word on the input channel, with i_first_byte marking
// byte 0 of a buffer, and writes it into a two-bank frame RAM. When the 25th byte of a
// frame lands, the frame is checked (byte 0 must be 0x0F, byte 24 must be 0x00); a bad
// frame is dropped silently. A good frame hands its bank to the readout sequencer, which
// reads bytes 1..14 and 23 one per cycle from the RAM's read port, unpacks channels 0..9
// and pushes them through a three-stage centre-and-scale pipeline (one 12x21 multiply);
// the readout engine stays busy until the frame's result word enters the output register.
// Bytes are taken one per cycle while o_in_ready is high; new frames fill the other bank
// while the readout runs. o_in_ready drops only on the last byte of a frame while the
// readout engine is still busy with the previous frame, either reading it out or
// holding its result until the output register has room. A start mark in mid-frame
// restarts collection; bytes outside a frame are dropped. Registers: channel_center at
// address 0, range_reciprocal at address 4; write them only while the block is idle.

module sbus_frame_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // byte input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_first_byte,
    // decoded frame output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [15:0]            o_left_x,
    output logic signed [15:0]            o_left_y,
    output logic signed [15:0]            o_right_x,
    output logic signed [15:0]            o_right_y,
    output logic [10:0]                   o_switch_one,
    output logic [10:0]                   o_switch_two,
    output logic [10:0]                   o_switch_three,
    output logic [10:0]                   o_switch_four,
    output logic signed [15:0]            o_wheel_one,
    output logic signed [15:0]            o_wheel_two,
    output logic                          o_safe_flag
);

    // ---------------------------------------------------------------- config registers
    logic [10:0] r_center;
    logic [19:0] r_recip;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= sfd_pkg::CENTER_RESET;
            r_recip  <= sfd_pkg::RECIP_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                sfd_pkg::REG_CENTER: r_center <= pwdata[10:0];
                sfd_pkg::REG_RECIP:  r_recip  <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            sfd_pkg::REG_CENTER: prdata = {21'd0, r_center};
            sfd_pkg::REG_RECIP:  prdata = {12'd0, r_recip};
            default:             prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- byte intake
    logic [sfd_pkg::CNT_BITS-1:0]  r_byte_count;
    logic                          r_start_ok;
    logic                          r_bank;
    sfd_pkg::t_eng_stat            eng_stat;
    logic                          in_acc;
    logic                          wr_en;
    logic [sfd_pkg::CNT_BITS-1:0]  wr_off;
    logic                          completing;
    logic                          launch;

    // hold the closing byte while the engine still owns a finished frame
    assign o_in_ready = !(eng_stat.busy && (r_byte_count == sfd_pkg::LAST_BYTE));
    assign in_acc     = i_in_valid && o_in_ready;

    assign completing = in_acc && !i_first_byte && (r_byte_count == sfd_pkg::LAST_BYTE);
    assign launch     = completing && r_start_ok && (i_data_byte == sfd_pkg::END_MARK);
    assign wr_en      = in_acc && (i_first_byte || (r_byte_count != '0));
    assign wr_off     = i_first_byte ? '0 : r_byte_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_start_ok   <= 1'b0;
            r_bank       <= 1'b0;
        end else if (in_acc) begin
            if (i_first_byte) begin
                r_byte_count <= sfd_pkg::CNT_BITS'(1);
                r_start_ok   <= (i_data_byte == sfd_pkg::START_MARK);
            end else if (completing) begin
                // frame done: back to idle, flip banks if the frame goes to readout
                r_byte_count <= '0;
                if (launch) begin
                    r_bank <= !r_bank;
                end
            end else if (r_byte_count != '0) begin
                r_byte_count <= r_byte_count + sfd_pkg::CNT_BITS'(1);
            end
        end
    end

    // ---------------------------------------------------------------- frame memory
    logic                          rd_en;
    logic [sfd_pkg::RAM_ABITS-1:0] rd_addr;
    logic [sfd_pkg::RAM_WIDTH-1:0] rd_data;

    sfd_ram #(
        .WIDTH (sfd_pkg::RAM_WIDTH),
        .DEPTH (sfd_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr ({r_bank, wr_off}),
        .i_wr_data (i_data_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ---------------------------------------------------------------- readout and scaling
    sfd_pkg::t_chan   chan;
    sfd_pkg::t_safe   safe;
    sfd_pkg::t_scaled scaled;
    logic             scale_empty;
    logic             finish;

    sfd_unpack u_unpack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (launch),
        .i_bank    (r_bank),
        .i_release (finish),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_chan    (chan),
        .o_safe    (safe),
        .o_stat    (eng_stat)
    );

    sfd_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_chan   (chan),
        .i_center (r_center),
        .i_recip  (r_recip),
        .o_scaled (scaled),
        .o_empty  (scale_empty)
    );

    // ---------------------------------------------------------------- result assembly
    logic signed [15:0] r_res_left_x;
    logic signed [15:0] r_res_left_y;
    logic signed [15:0] r_res_right_x;
    logic signed [15:0] r_res_right_y;
    logic [10:0]        r_res_sw_one;
    logic [10:0]        r_res_sw_two;
    logic [10:0]        r_res_sw_three;
    logic [10:0]        r_res_sw_four;
    logic signed [15:0] r_res_wheel_one;
    logic signed [15:0] r_res_wheel_two;
    logic               r_res_safe;

    always_ff @(posedge i_clk) begin
        if (safe.vld) begin
            r_res_safe <= safe.flag;
        end
        if (scaled.vld) begin
            unique case (scaled.num)
                sfd_pkg::CH_RIGHT_Y: r_res_right_y   <= scaled.val;
                sfd_pkg::CH_RIGHT_X: r_res_right_x   <= scaled.val;
                sfd_pkg::CH_LEFT_X:  r_res_left_x    <= scaled.val;
                sfd_pkg::CH_LEFT_Y:  r_res_left_y    <= scaled.val;
                sfd_pkg::CH_SW_ONE:  r_res_sw_one    <= scaled.raw;
                sfd_pkg::CH_SW_TWO:  r_res_sw_two    <= scaled.raw;
                sfd_pkg::CH_SW_THR:  r_res_sw_three  <= scaled.raw;
                sfd_pkg::CH_SW_FOUR: r_res_sw_four   <= scaled.raw;
                sfd_pkg::CH_WHEEL_1: r_res_wheel_one <= scaled.val;
                sfd_pkg::CH_WHEEL_2: r_res_wheel_two <= scaled.val;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- output register
    logic               r_out_valid;
    logic signed [15:0] r_left_x;
    logic signed [15:0] r_left_y;
    logic signed [15:0] r_right_x;
    logic signed [15:0] r_right_y;
    logic [10:0]        r_sw_one;
    logic [10:0]        r_sw_two;
    logic [10:0]        r_sw_three;
    logic [10:0]        r_sw_four;
    logic signed [15:0] r_wheel_one;
    logic signed [15:0] r_wheel_two;
    logic               r_safe;

    // advance the assembled frame once every channel is in and the slot is free
    assign finish = eng_stat.drained && scale_empty && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_left_x    <= r_res_left_x;
            r_left_y    <= r_res_left_y;
            r_right_x   <= r_res_right_x;
            r_right_y   <= r_res_right_y;
            r_sw_one    <= r_res_sw_one;
            r_sw_two    <= r_res_sw_two;
            r_sw_three  <= r_res_sw_three;
            r_sw_four   <= r_res_sw_four;
            r_wheel_one <= r_res_wheel_one;
            r_wheel_two <= r_res_wheel_two;
            r_safe      <= r_res_safe;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_x       = r_left_x;
    assign o_left_y       = r_left_y;
    assign o_right_x      = r_right_x;
    assign o_right_y      = r_right_y;
    assign o_switch_one   = r_sw_one;
    assign o_switch_two   = r_sw_two;
    assign o_switch_three = r_sw_three;
    assign o_switch_four  = r_sw_four;
    assign o_wheel_one    = r_wheel_one;
    assign o_wheel_two    = r_wheel_two;
    assign o_safe_flag    = r_safe;

endmodule

### hdl/sfd_checker.sv
// Port-level checker for the S-Bus frame decoder, bound to the top level.
// Depends on sbus_frame_decoder's port list.
`timescale 1ns / 1ps

module sfd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [sfd_pkg::ADDR_BITS-1:0] paddr,
    input logic [31:0]                   pwdata,
    input logic [31:0]                   prdata,
    input logic                          pready,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [7:0]                    i_data_byte,
    input logic                          i_first_byte,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [15:0]            o_left_x,
    input logic signed [15:0]            o_left_y,
    input logic signed [15:0]            o_right_x,
    input logic signed [15:0]            o_right_y,
    input logic [10:0]                   o_switch_one,
    input logic [10:0]                   o_switch_two,
    input logic [10:0]                   o_switch_three,
    input logic [10:0]                   o_switch_four,
    input logic signed [15:0]            o_wheel_one,
    input logic signed [15:0]            o_wheel_two,
    input logic                          o_safe_flag
);

    // stalled input word stays offered with its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_data_byte) && $stable(i_first_byte))
        else $error("input word changed while stalled");

    // stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    // stalled result word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_left_x) && $stable(o_left_y) && $stable(o_right_x)
            && $stable(o_right_y) && $stable(o_switch_one) && $stable(o_switch_two)
            && $stable(o_switch_three) && $stable(o_switch_four)
            && $stable(o_wheel_one) && $stable(o_wheel_two) && $stable(o_safe_flag))
        else $error("result payload changed while stalled");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word offered right after reset");

    // a center write reads back in the next cycle, upper bits zero
    a_center_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr[2] == sfd_pkg::REG_CENTER) |=>
            (paddr[2] != sfd_pkg::REG_CENTER)
            || (prdata == {21'd0, $past(pwdata[10:0])}))
        else $error("channel_center readback mismatch");

endmodule

bind sbus_frame_decoder sfd_checker u_sfd_checker (.*);

### test/testbench.sv
// Self-checking testbench for sbus_frame_decoder: feeds S-Bus bytes, predicts decoded words.
// Depends on sfd_pkg and the sbus_frame_decoder RTL; needs no files or arguments.
`timescale 1ns / 1ps

module testbench;

    // 0 left_x, 1 left_y, 2 right_x, 3 right_y, 4..7 switches, 8..9 wheels, 10 safe flag
    typedef logic [10:0][15:0] t_decoded;

    // one directed frame: stray bytes ahead, optional abandoned start, then the frame
    typedef struct packed {
        logic [2:0]  stray;
        logic [4:0]  cut;
        logic [10:0] center;
        logic [19:0] recip;
        logic [7:0]  start;
        logic [10:0] fill;
        logic [7:0]  flags;
        logic [7:0]  stop;
        logic        typed;
        logic [15:0] stick;
        logic        safe;
    } t_row;

    localparam int DIRECTED_ROWS   = 10;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int REPORT_CAP      = 200;
    localparam logic [sfd_pkg::ADDR_BITS-1:0] ADDR_CENTER = {sfd_pkg::REG_CENTER, 2'b00};
    localparam logic [sfd_pkg::ADDR_BITS-1:0] ADDR_RECIP  = {sfd_pkg::REG_RECIP, 2'b00};

    logic                          i_clk;
    logic                          i_rst_n      = 1'b0;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [sfd_pkg::ADDR_BITS-1:0] paddr        = '0;
    logic [31:0]                   pwdata       = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_ready;
    logic [7:0]                    i_data_byte  = '0;
    logic                          i_first_byte = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready  = 1'b0;
    logic signed [15:0]            o_left_x, o_left_y, o_right_x, o_right_y;
    logic [10:0]                   o_switch_one, o_switch_two, o_switch_three, o_switch_four;
    logic signed [15:0]            o_wheel_one, o_wheel_two;
    logic                          o_safe_flag;

    // predictor state, owned by the monitor
    logic [sfd_pkg::FRAME_BYTES*8-1:0] frame_bits;
    int                                collected;
    logic                              start_seen;
    logic [10:0]                       center_cfg;
    logic [19:0]                       recip_cfg;

    t_decoded decoded_q [$];
    t_decoded typed_frame;
    logic     typed_on = 1'b0;

    int src_idle_pct = 0;
    int stall_pct    = 0;
    int fail_count   = 0;
    int report_count = 0;
    int stuck_cycles = 0;

    string field_name [11] = '{"left_x", "left_y", "right_x", "right_y", "switch_one",
                               "switch_two", "switch_three", "switch_four", "wheel_one",
                               "wheel_two", "safe_flag"};

    // Directed frames. Rows with typed=1 carry an expectation worked out by hand; the
    // rest go through the predictor.
    t_row plan [DIRECTED_ROWS] = '{
        // stray bytes while idle after reset, all channels at zero
        '{3'd2, 5'd0, 11'd1024, 20'd99864, 8'h0F, 11'd0, 8'h00, 8'h00, 1'b1, -16'sd24966, 1'b0},
        // all channels at full scale, frame-lost bit
        '{3'd0, 5'd0, 11'd1024, 20'd99864, 8'h0F, 11'd2047, 8'h04, 8'h00, 1'b1, 16'sd24941, 1'b1},
        // stray bytes after a completed frame, channels centred, failsafe bit
        '{3'd3, 5'd0, 11'd1024, 20'd99864, 8'h0F, 11'd1024, 8'h08, 8'h00, 1'b1, 16'sd0, 1'b1},
        // start mark in mid-frame restarts collection
        '{3'd0, 5'd7, 11'd1024, 20'd99864, 8'h0F, 11'd1365, 8'hF3, 8'h00, 1'b0, 16'sd0, 1'b0},
        // restart on the very last byte, then a bad start byte
        '{3'd0, 5'd24, 11'd1024, 20'd99864, 8'h0E, 11'd0, 8'h00, 8'h00, 1'b0, 16'sd0, 1'b0},
        // bad end byte
        '{3'd0, 5'd0, 11'd1024, 20'd99864, 8'h0F, 11'd0, 8'h00, 8'h80, 1'b0, 16'sd0, 1'b0},
        // positive saturation at the largest reciprocal
        '{3'd0, 5'd0, 11'd0, 20'd1048575, 8'h0F, 11'd2047, 8'hFF, 8'h00, 1'b1, 16'sd32767, 1'b1},
        // negative saturation
        '{3'd1, 5'd0, 11'd2047, 20'd1048575, 8'h0F, 11'd0, 8'h00, 8'h00, 1'b1, -16'sd32768, 1'b0},
        // zero reciprocal flattens every analog channel
        '{3'd0, 5'd0, 11'd0, 20'd0, 8'h0F, 11'd2047, 8'h0C, 8'h00, 1'b1, 16'sd0, 1'b1},
        '{3'd0, 5'd0, 11'd2047, 20'd0, 8'h0F, 11'd1234, 8'h00, 8'h00, 1'b1, 16'sd0, 1'b0}
    };

    sbus_frame_decoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_left_x       (o_left_x),
        .o_left_y       (o_left_y),
        .o_right_x      (o_right_x),
        .o_right_y      (o_right_y),
        .o_switch_one   (o_switch_one),
        .o_switch_two   (o_switch_two),
        .o_switch_three (o_switch_three),
        .o_switch_four  (o_switch_four),
        .o_wheel_one    (o_wheel_one),
        .o_wheel_two    (o_wheel_two),
        .o_safe_flag    (o_safe_flag)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Centre a raw channel, scale by the reciprocal, floor-shift by 12 and clamp to 16 bits.
    function automatic logic [15:0] scale_stick(input logic [10:0] raw, input logic [10:0] ctr,
                                                input logic [19:0] rcp);
        longint centred;
        longint prod;
        longint q;
        centred = raw;
        centred = centred - longint'(ctr);
        prod = centred * longint'(rcp);
        q = prod >>> 12;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    // Unpack channels 0..9 from a complete frame (LSB first from byte 1) into a decoded word.
    function automatic t_decoded decode_frame(input logic [sfd_pkg::FRAME_BYTES*8-1:0] fb,
                                              input logic [10:0] ctr, input logic [19:0] rcp);
        logic [10:0] chan [10];
        t_decoded    r;
        for (int k = 0; k < 10; k++)
            chan[k] = fb[8 + 11*k +: 11];
        r[0]  = scale_stick(chan[2], ctr, rcp);
        r[1]  = scale_stick(chan[3], ctr, rcp);
        r[2]  = scale_stick(chan[1], ctr, rcp);
        r[3]  = scale_stick(chan[0], ctr, rcp);
        for (int k = 4; k < 8; k++)
            r[k] = {5'b0, chan[k]};
        r[8]  = scale_stick(chan[8], ctr, rcp);
        r[9]  = scale_stick(chan[9], ctr, rcp);
        r[10] = {15'b0, fb[8*23 + 2] | fb[8*23 + 3]};
        return r;
    endfunction

    // Offer one byte. Called just after a falling edge; returns just after the falling
    // edge that follows acceptance, with valid still high so the next word can follow
    // back to back.
    task automatic send_byte(input logic [7:0] b, input logic first);
        logic taken;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_first_byte <= first;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = o_in_ready;
            @(negedge i_clk);
        end
    endtask

    // Send the first nbytes of a frame, marking byte 0.
    task automatic send_frame(input logic [sfd_pkg::FRAME_BYTES*8-1:0] fb, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            send_byte(fb[8*i +: 8], i == 0);
    endtask

    // APB write: setup cycle, then access cycle. Leaves psel high; the caller drops it.
    task automatic apb_write(input logic [sfd_pkg::ADDR_BITS-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every decoded word is out and the readout has settled,
    // then load both registers.
    task automatic write_regs(input logic [10:0] ctr, input logic [19:0] rcp);
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        apb_write(ADDR_CENTER, {21'b0, ctr});
        apb_write(ADDR_RECIP, {12'b0, rcp});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: track register writes, run the predictor on every accepted input word and
    // check every accepted output word against the oldest expectation.
    always @(posedge i_clk) begin
        t_decoded got;
        t_decoded want;
        if (!i_rst_n) begin
            collected  = 0;
            start_seen = 1'b0;
            center_cfg = sfd_pkg::CENTER_RESET;
            recip_cfg  = sfd_pkg::RECIP_RESET;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_CENTER)
                    center_cfg = pwdata[10:0];
                else if (paddr == ADDR_RECIP)
                    recip_cfg = pwdata[19:0];
            end
            if (i_in_valid && o_in_ready) begin
                if (i_first_byte) begin
                    // a mark always restarts collection, even mid-frame
                    frame_bits[7:0] = i_data_byte;
                    start_seen = (i_data_byte == sfd_pkg::START_MARK);
                    collected = 1;
                end else if (collected != 0) begin
                    frame_bits[8*collected +: 8] = i_data_byte;
                    collected++;
                    if (collected == sfd_pkg::FRAME_BYTES) begin
                        collected = 0;
                        if (start_seen && frame_bits[8*(sfd_pkg::FRAME_BYTES-1) +: 8]
                                          == sfd_pkg::END_MARK)
                            decoded_q.push_back(typed_on ? typed_frame
                                : decode_frame(frame_bits, center_cfg, recip_cfg));
                    end
                end
                // unmarked bytes while idle are dropped
            end
            if (o_out_valid && i_out_ready) begin
                got[0]  = o_left_x;
                got[1]  = o_left_y;
                got[2]  = o_right_x;
                got[3]  = o_right_y;
                got[4]  = {5'b0, o_switch_one};
                got[5]  = {5'b0, o_switch_two};
                got[6]  = {5'b0, o_switch_three};
                got[7]  = {5'b0, o_switch_four};
                got[8]  = o_wheel_one;
                got[9]  = o_wheel_two;
                got[10] = {15'b0, o_safe_flag};
                if (decoded_q.size() == 0) begin
                    fail_count++;
                    if (report_count++ < REPORT_CAP)
                        $display("%0t: decoded word with none expected, left_x %0d",
                                 $time, $signed(got[0]));
                end else begin
                    want = decoded_q.pop_front();
                    for (int f = 0; f < 11; f++) begin
                        if (got[f] !== want[f]) begin
                            fail_count++;
                            if (report_count++ < REPORT_CAP)
                                $display("%0t: %s expected %0d got %0d", $time, field_name[f],
                                         $signed(want[f]), $signed(got[f]));
                        end
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_row                              r;
        logic [sfd_pkg::FRAME_BYTES*8-1:0] fb;
        logic [175:0]                      payload;
        logic [10:0]                       ctr, ch;
        logic [19:0]                       rcp;
        logic [7:0]                        start, flags, stop;
        int                                nbytes, kind, sent;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames, no idling.
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            r = plan[i];
            write_regs(r.center, r.recip);
            repeat (r.stray) send_byte(8'($urandom_range(255)), 1'b0);
            if (r.cut != 0) begin
                for (int w = 0; w < sfd_pkg::FRAME_BYTES; w++)
                    fb[8*w +: 8] = 8'($urandom_range(255));
                fb[7:0] = sfd_pkg::START_MARK;
                send_frame(fb, r.cut);
            end
            typed_frame = {{15'b0, r.safe}, r.stick, r.stick, {4{5'b0, r.fill}},
                           r.stick, r.stick, r.stick, r.stick};
            typed_on = r.typed;
            send_frame({r.stop, r.flags, {16{r.fill}}, r.start}, sfd_pkg::FRAME_BYTES);
            typed_on = 1'b0;
        end

        // Random frames: mostly well formed with random channel content, the rest bad
        // start or end bytes, abandoned starts and line noise.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  stall_pct = 0;  end
                1: begin src_idle_pct = 72; stall_pct = 0;  end
                2: begin src_idle_pct = 0;  stall_pct = 72; end
                default: begin src_idle_pct = 28; stall_pct = 28; end
            endcase
            case (ph)
                0: begin ctr = 11'd0;                 rcp = 20'd1048575;          end
                1: begin ctr = 11'd2047;              rcp = 20'd0;                end
                2: begin ctr = sfd_pkg::CENTER_RESET; rcp = sfd_pkg::RECIP_RESET; end
                3: begin ctr = 11'd2047;              rcp = 20'd1048575;          end
                4: begin ctr = 11'd0;                 rcp = 20'd0;                end
                default: begin
                    ctr = 11'($urandom_range(2047));
                    rcp = 20'($urandom_range(1048575));
                end
            endcase
            // the sender waits here until every decoded word has come back
            write_regs(ctr, rcp);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                kind = $urandom_range(99);
                for (int k = 0; k < 16; k++) begin
                    case ($urandom_range(5))
                        0: ch = 11'd0;
                        1: ch = 11'd2047;
                        2: ch = ctr;
                        default: ch = 11'($urandom_range(2047));
                    endcase
                    payload[11*k +: 11] = ch;
                end
                start  = sfd_pkg::START_MARK;
                stop   = sfd_pkg::END_MARK;
                flags  = 8'($urandom_range(255));
                nbytes = sfd_pkg::FRAME_BYTES;
                if (kind < 8)
                    start = 8'($urandom_range(255));
                else if (kind < 15)
                    stop = 8'($urandom_range(1, 255));
                else if (kind < 21)
                    nbytes = $urandom_range(1, sfd_pkg::FRAME_BYTES - 1);
                else if (kind < 26)
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)), 1'b0);
                send_frame({stop, flags, payload, start}, nbytes);
                sent += nbytes;
            end
        end

        // Drain: wait for every expected word, then give the block time to misbehave.
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && decoded_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
hdl/sfd_pkg.sv
hdl/sfd_ram.sv
hdl/sfd_unpack.sv
hdl/sfd_scale.sv
hdl/sbus_frame_decoder.sv
hdl/sfd_checker.sv
test/testbench.sv
